/* src/twc_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// twc_pkg
// shared types, constants and helpers of the text window console
// ---------------------------------------------------------------------------
package twc_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int TAB_STOP    = 8;
  localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);

  localparam int ROW_W     = 5;
  localparam int COL_W     = 7;
  localparam int ATTR_W    = 8;
  localparam int CODE_W    = 8;
  localparam int CELL_W    = ATTR_W + CODE_W;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CODE_W-1:0] CH_BS      = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF      = 8'h0a;
  localparam logic [CODE_W-1:0] CH_CR      = 8'h0d;
  localparam logic [CODE_W-1:0] CH_PRT_LO  = 8'h20;
  localparam logic [CODE_W-1:0] CH_PRT_HI  = 8'h7f;
  localparam logic [CODE_W-1:0] BLANK_CODE = 8'h20;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_ATTR   = 3'd4;

  typedef logic [1:0] walk_kind_t;
  localparam walk_kind_t WK_INIT  = 2'd0;
  localparam walk_kind_t WK_CLEAR = 2'd1;
  localparam walk_kind_t WK_COPY  = 2'd2;
  localparam walk_kind_t WK_BLANK = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CODE_W-1:0] char_code;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
  } twc_req_t;

  typedef struct packed {
    logic [ROW_W-1:0]  pos_row;
    logic [COL_W-1:0]  pos_col;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } twc_rsp_t;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       walk_init;
    walk_kind_t kind;
    logic       walk_next;
    logic       walk_rd;
    logic       walk_wr;
  } twc_ctl_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scroll_req;
    logic            scroll_ok;
    logic            clear_empty;
    logic            walk_last;
  } twc_sts_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col);
  endfunction

endpackage
`default_nettype wire

/* src/text_window_console_top.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// text_window_console_top
// text-mode console window over an 80x25 cell buffer
// ---------------------------------------------------------------------------
// After reset the block clears its 2000-cell buffer, one cell per cycle, and
// holds busy high until that is done; window registers are taken only while
// busy is low (cfg_ready follows !busy). An item is taken when start is high
// and busy is low. A clear blanks each interior cell on screen in turn. A
// scroll reads then writes each moved cell on the single buffer port pair,
// then blanks each cell of the last interior row. Each result is shown for
// one cycle with done high and cannot be held off; the next item may start in
// that same cycle.
module text_window_console_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire twc_pkg::twc_req_t             req,
  output logic                               done,
  output twc_pkg::twc_rsp_t                  rsp,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [twc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [twc_pkg::CFG_DAT_W-1:0] cfg_data
);
  import twc_pkg::*;

  twc_ctl_t ctl;
  twc_sts_t sts;
  logic     cfg_we;

  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  twc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .sts   (sts),
    .ctl   (ctl)
  );

  twc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .rsp       (rsp),
    .cfg_valid (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back to back result strobes");

  a_scroll_data: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.scrolled) |-> (rsp.cell_data == '0))
    else $error("scrolled put returned cell data");

endmodule
`default_nettype wire

/* src/twc_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// twc_ctrl
// sequencer: buffer init, item execution, scroll copy, blank and clear walks
// ---------------------------------------------------------------------------
module twc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  output logic                 done,
  input  wire twc_pkg::twc_sts_t sts,
  output twc_pkg::twc_ctl_t    ctl
);
  import twc_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_CP_RD = 3'd3;
  localparam logic [2:0] S_CP_WR = 3'd4;
  localparam logic [2:0] S_BLANK = 3'd5;
  localparam logic [2:0] S_CLEAR = 3'd6;

  logic [2:0] state, state_next;
  logic       done_next;

  always_comb begin
    ctl        = '0;
    ctl.kind   = WK_INIT;
    state_next = state;
    done_next  = 1'b0;
    unique case (state) inside
      S_INIT: begin
        ctl.walk_wr = 1'b1;
        if (sts.walk_last) begin
          state_next = S_IDLE;
        end else begin
          ctl.walk_next = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.op == OP_PUT && sts.scroll_req && sts.scroll_ok) begin
          ctl.walk_init = 1'b1;
          ctl.kind      = WK_COPY;
          state_next    = S_CP_RD;
        end else if (sts.op == OP_CLEAR && !sts.clear_empty) begin
          ctl.walk_init = 1'b1;
          ctl.kind      = WK_CLEAR;
          state_next    = S_CLEAR;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CP_RD: begin
        ctl.walk_rd = 1'b1;
        state_next  = S_CP_WR;
      end
      S_CP_WR: begin
        ctl.walk_wr = 1'b1;
        if (sts.walk_last) begin
          ctl.walk_init = 1'b1;
          ctl.kind      = WK_BLANK;
          state_next    = S_BLANK;
        end else begin
          ctl.walk_next = 1'b1;
          state_next    = S_CP_RD;
        end
      end
      S_BLANK, S_CLEAR: begin
        ctl.walk_wr = 1'b1;
        if (sts.walk_last) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.walk_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

/* src/twc_dpath.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// twc_dpath
// window registers, cursor, cell buffer, walk counters and result registers
// ---------------------------------------------------------------------------
module twc_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire twc_pkg::twc_req_t             req,
  input  wire twc_pkg::twc_ctl_t             ctl,
  output twc_pkg::twc_sts_t                  sts,
  output twc_pkg::twc_rsp_t                  rsp,
  input  wire logic                          cfg_valid,
  input  wire logic [twc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [twc_pkg::CFG_DAT_W-1:0] cfg_data
);
  import twc_pkg::*;

  localparam int RX_W = ROW_W + 1;
  localparam int CX_W = COL_W + 1;

  typedef struct packed {
    logic [RX_W-1:0] row_lo;
    logic [RX_W-1:0] row_hi;
    logic [CX_W-1:0] col_lo;
    logic [CX_W-1:0] col_hi;
  } bounds_t;

  // window registers
  logic [ROW_W-1:0]  win_top, win_bottom;
  logic [COL_W-1:0]  win_left, win_right;
  logic [ATTR_W-1:0] win_attr;

  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  twc_req_t          item;
  logic              scrolled;
  logic              data_sel;

  logic [ROW_W-1:0]  wrow;
  logic [COL_W-1:0]  wcol;
  walk_kind_t        region;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata;

  logic [RX_W-1:0]   bot_x, top_x, row_n;
  logic [CX_W-1:0]   right_x, left_x, home, col_n, put_col;
  logic [CODE_W-1:0] put_code;
  logic              put_we, put_on, rd_on;
  logic              scroll_req;
  logic [CELL_W-1:0] blank;
  bounds_t           cur_b, init_b, clr_b;

  function automatic bounds_t region_bounds(input walk_kind_t k,
                                            input logic [ROW_W-1:0] t,
                                            input logic [COL_W-1:0] l,
                                            input logic [ROW_W-1:0] b,
                                            input logic [COL_W-1:0] r);
    bounds_t         bd;
    logic [RX_W-1:0] bx;
    logic [CX_W-1:0] rx;
    bx = {1'b0, b};
    rx = {1'b0, r};
    bd.col_lo = {1'b0, l} + CX_W'(1);
    bd.col_hi = rx;
    case (k)
      WK_INIT: begin
        bd.row_lo = '0;
        bd.row_hi = RX_W'(SCREEN_ROWS);
        bd.col_lo = '0;
        bd.col_hi = CX_W'(SCREEN_COLS);
      end
      WK_CLEAR: begin
        bd.row_lo = {1'b0, t} + RX_W'(1);
        bd.row_hi = (bx < RX_W'(SCREEN_ROWS)) ? bx : RX_W'(SCREEN_ROWS);
        bd.col_hi = (rx < CX_W'(SCREEN_COLS)) ? rx : CX_W'(SCREEN_COLS);
      end
      WK_COPY: begin
        bd.row_lo = {1'b0, t} + RX_W'(1);
        bd.row_hi = bx - RX_W'(1);
      end
      default: begin
        bd.row_lo = bx - RX_W'(1);
        bd.row_hi = bx;
      end
    endcase
    return bd;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      win_top    <= ROW_W'(0);
      win_left   <= COL_W'(0);
      win_bottom <= ROW_W'(24);
      win_right  <= COL_W'(79);
      win_attr   <= ATTR_W'(7);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIN_TOP:    win_top    <= cfg_data[ROW_W-1:0];
        REG_WIN_LEFT:   win_left   <= cfg_data[COL_W-1:0];
        REG_WIN_BOTTOM: win_bottom <= cfg_data[ROW_W-1:0];
        REG_WIN_RIGHT:  win_right  <= cfg_data[COL_W-1:0];
        REG_WIN_ATTR:   win_attr   <= cfg_data[ATTR_W-1:0];
        default: ;
      endcase
    end
  end

  // put step
  always_comb begin
    top_x    = {1'b0, win_top};
    bot_x    = {1'b0, win_bottom};
    left_x   = {1'b0, win_left};
    right_x  = {1'b0, win_right};
    blank    = {win_attr, BLANK_CODE};
    home     = left_x + CX_W'(1);
    row_n    = {1'b0, cur_row};
    col_n    = {1'b0, cur_col};
    put_we   = 1'b0;
    put_col  = col_n;
    put_code = item.char_code;
    if (item.char_code == CH_BS && col_n > home) begin
      put_col  = col_n - CX_W'(1);
      col_n    = put_col;
      put_we   = 1'b1;
      put_code = BLANK_CODE;
    end else if (item.char_code == CH_TAB) begin
      col_n = (col_n & ~CX_W'(TAB_STOP - 1)) + CX_W'(TAB_STOP);
    end else if (item.char_code == CH_CR) begin
      col_n = home;
    end else if (item.char_code == CH_LF) begin
      col_n = home;
      row_n = row_n + RX_W'(1);
    end else if (item.char_code >= CH_PRT_LO && item.char_code <= CH_PRT_HI) begin
      put_we = 1'b1;
      col_n  = col_n + CX_W'(1);
    end
    if (col_n >= right_x) begin
      col_n = home;
      row_n = row_n + RX_W'(1);
    end
    scroll_req = (row_n >= bot_x);
    if (scroll_req) begin
      row_n = bot_x - RX_W'(1);
      col_n = home;
    end
    put_on = ({1'b0, cur_row} < RX_W'(SCREEN_ROWS)) && (put_col < CX_W'(SCREEN_COLS));
    rd_on  = ({1'b0, item.cell_row} < RX_W'(SCREEN_ROWS)) &&
             ({1'b0, item.cell_col} < CX_W'(SCREEN_COLS));
  end

  // walk bounds and status
  always_comb begin
    cur_b  = region_bounds(region, win_top, win_left, win_bottom, win_right);
    init_b = region_bounds(ctl.kind, win_top, win_left, win_bottom, win_right);
    clr_b  = region_bounds(WK_CLEAR, win_top, win_left, win_bottom, win_right);
    sts.op          = item.opcode;
    sts.scroll_req  = scroll_req;
    sts.scroll_ok   = (bot_x >= top_x + RX_W'(3)) && (right_x >= left_x + CX_W'(3)) &&
                      (bot_x <= RX_W'(SCREEN_ROWS)) && (right_x <= CX_W'(SCREEN_COLS));
    sts.clear_empty = (clr_b.row_lo >= clr_b.row_hi) || (clr_b.col_lo >= clr_b.col_hi);
    sts.walk_last   = ({1'b0, wcol} + CX_W'(1) == cur_b.col_hi) &&
                      ({1'b0, wrow} + RX_W'(1) == cur_b.row_hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrow   <= '0;
      wcol   <= '0;
      region <= WK_INIT;
    end else if (ctl.walk_init) begin
      wrow   <= init_b.row_lo[ROW_W-1:0];
      wcol   <= init_b.col_lo[COL_W-1:0];
      region <= ctl.kind;
    end else if (ctl.walk_next) begin
      if ({1'b0, wcol} + CX_W'(1) == cur_b.col_hi) begin
        wcol <= cur_b.col_lo[COL_W-1:0];
        wrow <= wrow + ROW_W'(1);
      end else begin
        wcol <= wcol + COL_W'(1);
      end
    end
  end

  // cursor, item and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row  <= ROW_W'(1);
      cur_col  <= COL_W'(1);
      scrolled <= 1'b0;
      data_sel <= 1'b0;
    end else if (ctl.exec) begin
      scrolled <= (item.opcode == OP_PUT) && scroll_req;
      data_sel <= (item.opcode == OP_READ) && rd_on;
      if (item.opcode == OP_PUT) begin
        cur_row <= row_n[ROW_W-1:0];
        cur_col <= col_n[COL_W-1:0];
      end else if (item.opcode == OP_CLEAR) begin
        cur_row <= win_top + ROW_W'(1);
        cur_col <= win_left + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item <= req;
    end
  end

  // cell buffer ports
  always_comb begin
    mem_we = 1'b0;
    waddr  = cell_addr(wrow, wcol);
    wdata  = blank;
    if (ctl.exec) begin
      mem_we = (item.opcode == OP_PUT) && put_we && put_on;
      waddr  = cell_addr(cur_row, put_col[COL_W-1:0]);
      wdata  = {win_attr, put_code};
    end else if (ctl.walk_wr) begin
      mem_we = 1'b1;
      case (region)
        WK_INIT: wdata = '0;
        WK_COPY: wdata = rd_data;
        default: wdata = blank;
      endcase
    end
    mem_re = ctl.walk_rd || (ctl.exec && item.opcode == OP_READ && rd_on);
    raddr  = ctl.walk_rd ? cell_addr(wrow + ROW_W'(1), wcol)
                         : cell_addr(item.cell_row, item.cell_col);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_data <= mem[raddr];
    end
  end

  assign rsp.pos_row   = cur_row;
  assign rsp.pos_col   = cur_col;
  assign rsp.cell_data = data_sel ? rd_data : '0;
  assign rsp.scrolled  = scrolled;

endmodule
`default_nettype wire

/* test/twc_console_checker.sv */
// ---------------------------------------------------------------------------
// twc_console_checker
// watches the item, result and register channels of the text window console,
// keeps its own copy of the cell buffer, cursor and window registers, works
// out the report that each accepted item should give and compares every
// result strobe with the oldest report still waiting
// ---------------------------------------------------------------------------
module twc_console_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  twc_pkg::twc_req_t             req,
  input  logic                          done,
  input  twc_pkg::twc_rsp_t             rsp,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [twc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [twc_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import twc_pkg::*;

  logic [CELL_W-1:0] screen [CELL_COUNT];
  logic [ROW_W-1:0]  crow;
  logic [COL_W-1:0]  ccol;
  logic [ROW_W-1:0]  w_top;
  logic [ROW_W-1:0]  w_bottom;
  logic [COL_W-1:0]  w_left;
  logic [COL_W-1:0]  w_right;
  logic [ATTR_W-1:0] w_attr;
  twc_rsp_t          want_reports [$];
  int                fails;

  function automatic logic [CELL_W-1:0] blank();
    return {w_attr, BLANK_CODE};
  endfunction

  function automatic void store_cell(int r, int c, logic [CELL_W-1:0] v);
    if (r >= 0 && r < SCREEN_ROWS && c >= 0 && c < SCREEN_COLS) begin
      screen[r * SCREEN_COLS + c] = v;
    end
  endfunction

  function automatic void scroll_window();
    int r1;
    int r2;
    int c1;
    int c2;
    r1 = int'(w_top) + 1;
    r2 = int'(w_bottom) - 1;
    c1 = int'(w_left) + 1;
    c2 = int'(w_right) - 1;
    // collapsed or off-screen interior leaves the buffer alone
    if (!(r2 > r1 && c2 > c1 && r2 < SCREEN_ROWS && c2 < SCREEN_COLS)) return;
    for (int r = r1; r < r2; r++) begin
      for (int c = c1; c <= c2; c++) begin
        screen[r * SCREEN_COLS + c] = screen[(r + 1) * SCREEN_COLS + c];
      end
    end
    for (int c = c1; c <= c2; c++) begin
      screen[r2 * SCREEN_COLS + c] = blank();
    end
  endfunction

  function automatic void clear_window();
    for (int r = int'(w_top) + 1; r < int'(w_bottom); r++) begin
      for (int c = int'(w_left) + 1; c < int'(w_right); c++) begin
        store_cell(r, c, blank());
      end
    end
  endfunction

  function automatic twc_rsp_t predict_report(twc_req_t r);
    twc_rsp_t res;
    int       row;
    int       col;
    int       home;
    res = '0;
    case (r.opcode)
      OP_PUT: begin
        row  = int'(crow);
        col  = int'(ccol);
        home = int'(w_left) + 1;
        if (r.char_code == CH_BS && col > home) begin
          col--;
          store_cell(row, col, blank());
        end else if (r.char_code == CH_TAB) begin
          col = (col / TAB_STOP + 1) * TAB_STOP;
        end else if (r.char_code == CH_CR) begin
          col = home;
        end else if (r.char_code == CH_LF) begin
          col = home;
          row++;
        end else if (r.char_code >= CH_PRT_LO && r.char_code <= CH_PRT_HI) begin
          store_cell(row, col, {w_attr, r.char_code});
          col++;
        end
        if (col >= int'(w_right)) begin
          col = home;
          row++;
        end
        if (row >= int'(w_bottom)) begin
          scroll_window();
          row = int'(w_bottom) - 1;
          col = home;
          res.scrolled = 1'b1;
        end
        // wrap and scroll look at the full values, the registers keep low bits
        crow = row[ROW_W-1:0];
        ccol = col[COL_W-1:0];
      end
      OP_READ: begin
        if (r.cell_row < SCREEN_ROWS && r.cell_col < SCREEN_COLS) begin
          res.cell_data = screen[int'(r.cell_row) * SCREEN_COLS + int'(r.cell_col)];
        end
      end
      OP_CLEAR: begin
        clear_window();
        crow = w_top + 1'b1;
        ccol = w_left + 1'b1;
      end
      default: ;
    endcase
    res.pos_row = crow;
    res.pos_col = ccol;
    return res;
  endfunction

  task automatic check_field(string name, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    twc_rsp_t want;
    if (rst) begin
      for (int i = 0; i < CELL_COUNT; i++) screen[i] = '0;
      crow     = 1;
      ccol     = 1;
      w_top    = 0;
      w_left   = 0;
      w_bottom = 24;
      w_right  = 79;
      w_attr   = 7;
      want_reports.delete();
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIN_TOP:    w_top    = cfg_data[ROW_W-1:0];
          REG_WIN_LEFT:   w_left   = cfg_data[COL_W-1:0];
          REG_WIN_BOTTOM: w_bottom = cfg_data[ROW_W-1:0];
          REG_WIN_RIGHT:  w_right  = cfg_data[COL_W-1:0];
          REG_WIN_ATTR:   w_attr   = cfg_data[ATTR_W-1:0];
          default: ;
        endcase
      end
      if (done) begin
        if (want_reports.size() == 0) begin
          $error("result with no item waiting: row %0d col %0d data 0x%0h scrolled %0b",
                 rsp.pos_row, rsp.pos_col, rsp.cell_data, rsp.scrolled);
          fails++;
        end else begin
          want = want_reports.pop_front();
          check_field("pos_row", CELL_W'(want.pos_row), CELL_W'(rsp.pos_row));
          check_field("pos_col", CELL_W'(want.pos_col), CELL_W'(rsp.pos_col));
          check_field("cell_data", want.cell_data, rsp.cell_data);
          check_field("scrolled", CELL_W'(want.scrolled), CELL_W'(rsp.scrolled));
        end
      end
      if (start && !busy) want_reports.push_back(predict_report(req));
    end
    fail_count <= fails;
    pending    <= want_reports.size();
  end

endmodule

/* test/text_window_console_top_test.sv */
// ---------------------------------------------------------------------------
// text_window_console_top_test
// drives put, read and clear items into the text window console across a
// series of window settings, from the reset window through compact, collapsed
// and corner windows, with random idle gaps on both input channels; a checker
// beside the block predicts and compares every report
// ---------------------------------------------------------------------------
module text_window_console_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import twc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 40000;
  localparam int RANDOM_ITEMS = 1000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  twc_req_t             req = '0;
  logic                 done;
  twc_rsp_t             rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  int                   fail_count;
  int                   pending;

  logic [ROW_W-1:0] w_top = 0;
  logic [ROW_W-1:0] w_bottom = 24;
  logic [COL_W-1:0] w_left = 0;
  logic [COL_W-1:0] w_right = 79;
  bit               no_idle = 1'b0;
  int               quiet_cycles = 0;

  always #4 clk = ~clk;

  text_window_console_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  twc_console_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("text_window_console_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int idle_len();
    if (no_idle || $urandom_range(99) >= 12) return 0;
    return $urandom_range(1, 4);
  endfunction

  function automatic twc_req_t mk(logic [OP_W-1:0] op, logic [CODE_W-1:0] ch,
                                  logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    twc_req_t r;
    r.opcode    = op;
    r.char_code = ch;
    r.cell_row  = row;
    r.cell_col  = col;
    return r;
  endfunction

  task automatic send(twc_req_t r);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_window(logic [ROW_W-1:0] tp, logic [COL_W-1:0] lf,
                            logic [ROW_W-1:0] bt, logic [COL_W-1:0] rt,
                            logic [ATTR_W-1:0] at);
    write_reg(REG_WIN_TOP, CFG_DAT_W'(tp));
    write_reg(REG_WIN_LEFT, CFG_DAT_W'(lf));
    write_reg(REG_WIN_BOTTOM, CFG_DAT_W'(bt));
    write_reg(REG_WIN_RIGHT, CFG_DAT_W'(rt));
    write_reg(REG_WIN_ATTR, CFG_DAT_W'(at));
    cfg_valid <= 1'b0;
    w_top    = tp;
    w_left   = lf;
    w_bottom = bt;
    w_right  = rt;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic twc_req_t rand_item();
    twc_req_t r;
    int       pick;
    r.opcode    = OP_PUT;
    r.char_code = CODE_W'($urandom);
    r.cell_row  = ROW_W'($urandom);
    r.cell_col  = COL_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 20) r.opcode = OP_READ;
    else if (pick < 26) r.opcode = OP_CLEAR;
    else if (pick < 28) r.opcode = OP_UNUSED;
    if (r.opcode == OP_READ) begin
      pick = $urandom_range(99);
      // mostly aim at the window, sometimes anywhere, rest off-screen too
      if (pick < 55) begin
        r.cell_row = ROW_W'($urandom_range(w_top, w_bottom));
        r.cell_col = COL_W'($urandom_range(w_left, w_right));
      end else if (pick < 85) begin
        r.cell_row = ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
        r.cell_col = COL_W'($urandom_range(0, SCREEN_COLS - 1));
      end
    end else if (r.opcode == OP_PUT) begin
      pick = $urandom_range(99);
      if (pick < 55) r.char_code = CODE_W'($urandom_range(CH_PRT_LO, CH_PRT_HI));
      else if (pick < 65) r.char_code = CH_LF;
      else if (pick < 70) r.char_code = CH_CR;
      else if (pick < 78) r.char_code = CH_BS;
      else if (pick < 84) r.char_code = CH_TAB;
      else if (pick < 92) r.char_code = CODE_W'($urandom_range(0, CH_PRT_LO - 1));
    end
    return r;
  endfunction

  initial begin
    int               sent;
    int               phase;
    int               quiet_phase;
    int               kind;
    int               count;
    logic [ROW_W-1:0] tp;
    logic [ROW_W-1:0] bt;
    logic [COL_W-1:0] lf;
    logic [COL_W-1:0] rt;
    logic [ATTR_W-1:0] at;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset window, cursor at the interior home
    send(mk(OP_READ, 8'h00, 5'd0, 7'd0));
    send(mk(OP_PUT, 8'h41, 5'd0, 7'd0));
    send(mk(OP_PUT, CH_PRT_HI, 5'd0, 7'd0));
    send(mk(OP_PUT, CH_PRT_LO, 5'd0, 7'd0));
    send(mk(OP_PUT, CH_BS, 5'd0, 7'd0));
    send(mk(OP_READ, 8'h00, 5'd1, 7'd3));
    send(mk(OP_PUT, CH_CR, 5'd0, 7'd0));
    send(mk(OP_PUT, CH_BS, 5'd0, 7'd0));
    send(mk(OP_PUT, CH_TAB, 5'd0, 7'd0));
    send(mk(OP_PUT, 8'h00, 5'd0, 7'd0));
    send(mk(OP_PUT, 8'hff, 5'd0, 7'd0));
    send(mk(OP_PUT, CH_LF, 5'd0, 7'd0));
    send(mk(OP_READ, 8'h00, 5'd1, 7'd1));
    send(mk(OP_READ, 8'h00, 5'd24, 7'd79));
    send(mk(OP_READ, 8'h00, 5'd31, 7'd127));
    send(mk(OP_UNUSED, 8'hff, 5'd31, 7'd127));
    drain();

    // two-by-two interior: wrap, then scroll
    set_window(5'd20, 7'd70, 5'd23, 7'd73, 8'hff);
    send(mk(OP_CLEAR, 8'h00, 5'd0, 7'd0));
    for (int i = 0; i < 4; i++) send(mk(OP_PUT, CODE_W'(8'h61 + i), 5'd0, 7'd0));
    send(mk(OP_READ, 8'h00, 5'd21, 7'd71));
    drain();

    // inverted window: cursor lands off-screen and the scroll moves nothing
    set_window(5'd24, 7'd79, 5'd0, 7'd0, 8'h00);
    send(mk(OP_CLEAR, 8'h00, 5'd0, 7'd0));
    send(mk(OP_PUT, 8'h78, 5'd0, 7'd0));
    send(mk(OP_PUT, CH_BS, 5'd0, 7'd0));

    sent = 0;
    phase = 0;
    quiet_phase = $urandom_range(2, 8);
    while (sent < RANDOM_ITEMS) begin
      drain();
      kind = $urandom_range(0, 19);
      if (phase == 0) begin
        tp = 0;
        lf = 0;
        bt = 24;
        rt = 79;
        at = 8'hff;
        count = 16;
      end else if (kind < 12) begin
        tp = ROW_W'($urandom_range(0, 20));
        bt = tp + ROW_W'($urandom_range(2, 4));
        lf = COL_W'($urandom_range(0, 70));
        rt = lf + COL_W'($urandom_range(2, 9));
        at = ATTR_W'($urandom);
        count = $urandom_range(40, 90);
      end else if (kind < 15) begin
        // no interior rows
        tp = ROW_W'($urandom_range(0, 24));
        bt = ROW_W'($urandom_range(0, (tp == 24) ? 24 : tp + 1));
        lf = COL_W'($urandom_range(0, 79));
        rt = COL_W'($urandom_range(0, 79));
        at = ATTR_W'($urandom);
        count = $urandom_range(15, 30);
      end else if (kind < 18) begin
        tp = ROW_W'($urandom_range(0, 24));
        bt = ROW_W'($urandom_range(0, 24));
        lf = COL_W'($urandom_range(0, 79));
        rt = COL_W'($urandom_range(0, 79));
        at = ATTR_W'($urandom);
        count = $urandom_range(15, 30);
      end else begin
        tp = $urandom_range(1) ? 5'd24 : 5'd0;
        bt = $urandom_range(1) ? 5'd24 : 5'd0;
        lf = $urandom_range(1) ? 7'd79 : 7'd0;
        rt = $urandom_range(1) ? 7'd79 : 7'd0;
        at = $urandom_range(1) ? 8'hff : 8'h00;
        count = $urandom_range(15, 30);
      end
      set_window(tp, lf, bt, rt, at);
      no_idle = (phase == quiet_phase);
      if (phase == 0) begin
        // walk the full window down to its bottom border
        for (int i = 0; i < 24; i++) send(mk(OP_PUT, CH_LF, 5'd0, 7'd0));
        sent += 24;
      end
      repeat (count) send(rand_item());
      sent += count;
      phase++;
    end
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("text_window_console_top regression: pass");
    end else begin
      $display("text_window_console_top regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/twc_pkg.sv
src/twc_ctrl.sv
src/twc_dpath.sv
src/text_window_console_top.sv
test/twc_console_checker.sv
test/text_window_console_top_test.sv
